// ===== sv/lruc_pkg.sv =====
`timescale 1ns / 1ps

package lruc_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  // request codes
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_RESP
  } state_t;

endpackage

// ===== sv/lruc_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port entry RAM, one write and one registered read per cycle.
module lruc_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int WW    = 68
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [WW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [WW-1:0] rd_data
);

  logic [WW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/lru_cache_key_value_top.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_stall    in_req_type, in_key, in_value
// out_     output     out_valid / out_stall  out_hit, out_read_value, out_evicted,
//                                            out_evicted_key
// cfg_     input      cfg_we                 cfg_wdata (capacity)
//
// A get miss runs one scan pass over all entries and then responds; a hit or a
// put follows the scan with one read-modify-write pass that ages the ranks and
// writes the target. The entry RAM has a single read port, so each pass reads
// the entries one after another.
// Reset (rst_n low, synchronous) empties the store and sets capacity to 16.
// A stalled result holds in the output register while the next transaction runs.

module lru_cache_key_value_top #(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic signed [31:0] out_read_value,
  output logic               out_evicted,
  output logic signed [31:0] out_evicted_key,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata
);

  localparam int KW = lruc_pkg::KEY_W;
  localparam int DW = lruc_pkg::DATA_W;
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;   // index and rank width
  localparam int UW = $clog2(ENTRIES + 1);
  localparam int CW = (UW > lruc_pkg::CAP_W) ? UW : lruc_pkg::CAP_W;
  localparam int WW = KW + DW + AW;                           // {key, data, rank}
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  lruc_pkg::state_t state_r, state_nxt;

  logic [lruc_pkg::CAP_W-1:0] cap_r;
  logic [ENTRIES-1:0]         valid_r;
  logic [UW-1:0]              used_r;

  // request latched at acceptance
  logic          put_r;
  logic [KW-1:0] key_r;
  logic [DW-1:0] val_r;

  // read address sequencing
  logic [AW-1:0] cnt_r;
  logic          issued_r;
  logic          rv_r;
  logic [AW-1:0] ridx_r;

  // scan findings
  logic          found_r;
  logic [AW-1:0] f_idx_r;
  logic [AW-1:0] f_age_r;
  logic [DW-1:0] f_data_r;
  logic          slot_r;
  logic [AW-1:0] slot_idx_r;
  logic          any_r;
  logic [AW-1:0] best_r;
  logic [AW-1:0] vict_r;
  logic [KW-1:0] vkey_r;

  // update plan
  logic [AW-1:0] tgt_r;
  logic [AW-1:0] limit_r;
  logic          inc_all_r;
  logic [DW-1:0] new_data_r;

  // pending result
  logic          res_hit_r;
  logic [DW-1:0] res_rd_r;
  logic          res_ev_r;
  logic [KW-1:0] res_evk_r;

  logic          out_valid_r;
  logic          out_hit_r;
  logic [DW-1:0] out_rd_r;
  logic          out_ev_r;
  logic [KW-1:0] out_evk_r;

  // RAM ports
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [WW-1:0] rd_data, wr_data;

  logic          accept;
  logic          out_load;

  lruc_ram #(
    .DEPTH (ENTRIES),
    .AW    (AW),
    .WW    (WW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // returned entry fields
  logic [KW-1:0] rd_key;
  logic [DW-1:0] rd_dat;
  logic [AW-1:0] rd_age;
  logic          cur_valid;
  logic          age_inc;

  assign rd_key    = rd_data[WW-1 -: KW];
  assign rd_dat    = rd_data[AW +: DW];
  assign rd_age    = rd_data[AW-1:0];
  assign cur_valid = valid_r[ridx_r];
  assign age_inc   = inc_all_r || (rd_age < limit_r);

  // capacity clamped to 1..ENTRIES
  logic [CW-1:0] cap_ext, eff_cap, used_ext;
  assign cap_ext  = CW'(cap_r);
  assign used_ext = CW'(used_r);

  always_comb begin
    priority if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // decision after the scan
  logic          dec_ins_slot;   // fill a free entry
  logic          dec_grow;       // used count goes up
  logic [AW-1:0] dec_tgt;

  always_comb begin
    dec_ins_slot = (used_ext < eff_cap) && slot_r;
    priority if (found_r) begin
      dec_tgt  = f_idx_r;
      dec_grow = 1'b0;
    end else if (dec_ins_slot) begin
      dec_tgt  = slot_idx_r;
      dec_grow = 1'b1;
    end else begin
      dec_tgt  = vict_r;
      dec_grow = !any_r;
    end
  end

  // ---------------- state machine ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lruc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = lruc_pkg::ST_SCAN;
        end
      end
      lruc_pkg::ST_SCAN: begin
        if (rv_r && ridx_r == LAST) begin
          state_nxt = lruc_pkg::ST_DECIDE;
        end
      end
      lruc_pkg::ST_DECIDE: begin
        if (found_r || put_r == lruc_pkg::REQ_PUT) begin
          state_nxt = lruc_pkg::ST_UPDATE;
        end else begin
          state_nxt = lruc_pkg::ST_RESP;
        end
      end
      lruc_pkg::ST_UPDATE: begin
        if (rv_r && ridx_r == LAST) begin
          state_nxt = lruc_pkg::ST_RESP;
        end
      end
      lruc_pkg::ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = lruc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lruc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    rd_addr  = cnt_r;
    wr_en    = 1'b0;
    wr_addr  = ridx_r;
    wr_data  = {rd_key, rd_dat, rd_age + AW'(1)};
    out_load = 1'b0;
    unique case (state_r)
      lruc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      lruc_pkg::ST_SCAN: begin
        rd_en = !issued_r;
      end
      lruc_pkg::ST_DECIDE: begin
      end
      lruc_pkg::ST_UPDATE: begin
        rd_en = !issued_r;
        if (rv_r) begin
          if (ridx_r == tgt_r) begin
            wr_en   = 1'b1;
            wr_data = {key_r, new_data_r, AW'(0)};
          end else if (cur_valid && age_inc) begin
            wr_en = 1'b1;
          end
        end
      end
      lruc_pkg::ST_RESP: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
      end
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lruc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lruc_pkg::CAP_W'(16);
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // address sequencing for both passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      issued_r <= 1'b0;
      rv_r     <= 1'b0;
    end else begin
      rv_r <= rd_en;
      if (accept || state_r == lruc_pkg::ST_DECIDE) begin
        cnt_r    <= '0;
        issued_r <= 1'b0;
      end else if (rd_en) begin
        if (cnt_r == LAST) begin
          issued_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx_r <= rd_addr;
  end

  // latch request; collect scan findings
  always_ff @(posedge clk) begin
    if (accept) begin
      put_r   <= in_req_type;
      key_r   <= $unsigned(in_key);
      val_r   <= $unsigned(in_value);
      found_r <= 1'b0;
      slot_r  <= 1'b0;
      any_r   <= 1'b0;
      vict_r  <= '0;
    end else if (state_r == lruc_pkg::ST_SCAN && rv_r) begin
      if (!found_r && cur_valid && rd_key == key_r) begin
        found_r  <= 1'b1;
        f_idx_r  <= ridx_r;
        f_age_r  <= rd_age;
        f_data_r <= rd_dat;
      end
      if (!slot_r && !cur_valid) begin
        slot_r     <= 1'b1;
        slot_idx_r <= ridx_r;
      end
      // oldest entry: largest rank, first one wins ties
      if (cur_valid && (!any_r || rd_age > best_r)) begin
        any_r  <= 1'b1;
        best_r <= rd_age;
        vict_r <= ridx_r;
        vkey_r <= rd_key;
      end
    end
  end

  // plan the update pass and the result
  always_ff @(posedge clk) begin
    if (state_r == lruc_pkg::ST_DECIDE) begin
      tgt_r      <= dec_tgt;
      limit_r    <= f_age_r;
      inc_all_r  <= !found_r;
      new_data_r <= (put_r == lruc_pkg::REQ_PUT) ? val_r : f_data_r;
      res_hit_r  <= found_r;
      res_rd_r   <= (found_r && put_r == lruc_pkg::REQ_GET) ? f_data_r : '0;
      res_ev_r   <= !found_r && put_r == lruc_pkg::REQ_PUT && !dec_ins_slot && any_r;
      res_evk_r  <= (!found_r && put_r == lruc_pkg::REQ_PUT && !dec_ins_slot && any_r)
                    ? vkey_r : '0;
    end
  end

  // occupancy: new entry becomes valid at the decision
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
    end else if (state_r == lruc_pkg::ST_DECIDE && !found_r &&
                 put_r == lruc_pkg::REQ_PUT) begin
      valid_r[dec_tgt] <= 1'b1;
      if (dec_grow) begin
        used_r <= used_r + UW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r <= res_hit_r;
      out_rd_r  <= res_rd_r;
      out_ev_r  <= res_ev_r;
      out_evk_r <= res_evk_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = $signed(out_rd_r);
  assign out_evicted     = out_ev_r;
  assign out_evicted_key = $signed(out_evk_r);

`ifndef SYNTH
  // occupancy count tracks the valid bits
  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(used_r))
    else $error("used count does not match valid bits");

  // an accepted transaction always starts the scan pass
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == lruc_pkg::ST_SCAN)
    else $error("accepted transaction did not start scan");

  // read-modify-write never reads and writes one entry in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> wr_addr != rd_addr)
    else $error("RAM read and write collide on one entry");
`endif

endmodule
